// ----- hw/rtl/model_weight_update_select_assert.svh -----
// assertion macros for the model weight update and selection block
`ifndef MODEL_WEIGHT_UPDATE_SELECT_ASSERT_SVH
`define MODEL_WEIGHT_UPDATE_SELECT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MWUS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MWUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MWUS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MWUS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mwus_pkg.sv -----
// shared types and constants for the model weight update and selection block
`default_nettype none
package mwus_pkg;
   localparam int NUM_MODELS = 16;
   localparam int IDX_W      = 4;
   localparam int FRAC_BITS  = 16;
   localparam int SUM_W      = 20;
   localparam int CNT_W      = 5;
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int STEP_W     = 5;

   // input item modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_LIKE   = 2'd1;
   localparam logic [1:0] MODE_SELECT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_RULE     = 2'd0;
   localparam logic [1:0] CSR_MIN_PROB = 2'd1;
   localparam logic [1:0] CSR_ETA      = 2'd2;

   typedef enum logic [2:0] {
      ST_LOADED   = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_REJECTED = 3'd2,
      ST_SKIPPED  = 3'd3,
      ST_SELECTED = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       load_write;
      logic       mul_factor;
      logic       mul_write;
      logic       idx_clr;
      logic       idx_inc;
      logic       sum_clr;
      logic       sum_acc;
      logic       src_pend;
      logic       div_start;
      logic       div_step;
      logic       norm_write;
      logic       gather;
      logic       surv_clr;
      logic       apply_surv;
      logic       sync_write;
      logic       walk_clr;
      logic       walk_step;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       last;
      logic       cur_live;
      logic       idx_last;
      logic       div_done;
      logic       total_zero;
      logic       reject;
      logic       prune;
      logic       count_le1;
      logic       walk_hit;
      logic       rsp_free;
   } stat_type;

   function automatic logic [CNT_W-1:0] popcount(input logic [NUM_MODELS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < NUM_MODELS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mwus_datapath.sv -----
// weight storage, multiplier, serial divider, sums and response register
`default_nettype none
module mwus_datapath import mwus_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic [1:0]           req_mode,
   input  wire logic [IDX_W-1:0]     req_slot,
   input  wire logic [FRAC_BITS-1:0] req_value,
   input  wire logic                 req_last,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [IDX_W-1:0]          rsp_chosen_model,
   output logic [CNT_W-1:0]          rsp_live_count
);
   logic                  rule_ff;
   logic [FRAC_BITS-1:0]  min_prob_ff, eta_ff;
   logic [1:0]            mode_ff;
   logic                  last_ff;
   logic [FRAC_BITS-1:0]  value_ff;
   logic [FRAC_BITS-1:0]  weights_ff [NUM_MODELS];
   logic [FRAC_BITS-1:0]  pend_ff [NUM_MODELS];
   logic [NUM_MODELS-1:0] live_ff, live_in, surv_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      idx_ff, pick_ff, sole;
   logic [SUM_W-1:0]      total_ff, rem_ff, cum_ff, cum_next, src_ext;
   logic [FRAC_BITS:0]    factor_ff, factor_in, loss, quo_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [FRAC_BITS-1:0]  w_cur, src_word, norm_val;
   logic [32:0]           eta_prod, w_prod;
   logic [20:0]           thresh;
   logic [SUM_W:0]        trial, trial_sub;
   logic                  ge;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [IDX_W-1:0]      rsp_chosen_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   assign w_cur    = weights_ff[idx_ff];
   assign src_word = cmd.src_pend ? pend_ff[idx_ff] : w_cur;
   assign src_ext  = {{(SUM_W-FRAC_BITS){1'b0}}, src_word};

   // likelihood factor and weight product
   assign loss      = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, value_ff};
   assign eta_prod  = {16'b0, loss} * {17'b0, eta_ff};
   assign factor_in = rule_ff ? ({1'b1, {FRAC_BITS{1'b0}}} - eta_prod[32:16])
                              : {1'b0, value_ff};
   assign w_prod    = {17'b0, w_cur} * {16'b0, factor_ff};

   // restoring divider step
   assign trial     = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge        = trial >= {1'b0, total_ff};
   assign trial_sub = trial - {1'b0, total_ff};
   assign norm_val  = quo_ff[FRAC_BITS] ? {FRAC_BITS{1'b1}} : quo_ff[FRAC_BITS-1:0];

   assign thresh   = {16'b0, count_ff} * {5'b0, min_prob_ff};
   assign cum_next = cum_ff + {{(SUM_W-FRAC_BITS){1'b0}}, w_cur};

   // lowest live model
   always_comb begin
      sole = '0;
      for (int i = NUM_MODELS - 1; i >= 0; i--) begin
         if (live_ff[i]) sole = IDX_W'(i);
      end
   end

   always_comb begin
      live_in = live_ff;
      live_in[idx_ff] = 1'b1;
   end

   assign stat.mode       = mode_ff;
   assign stat.last       = last_ff;
   assign stat.cur_live   = live_ff[idx_ff];
   assign stat.idx_last   = idx_ff == IDX_W'(NUM_MODELS - 1);
   assign stat.div_done   = step_ff == STEP_W'(DIV_STEPS - 1);
   assign stat.total_zero = total_ff == '0;
   assign stat.reject     = (total_ff == '0) || ({1'b0, total_ff} < thresh);
   assign stat.prune      = (surv_ff != '0) && (surv_ff != live_ff);
   assign stat.count_le1  = count_ff <= CNT_W'(1);
   assign stat.walk_hit   = live_ff[idx_ff] && ({{(SUM_W-FRAC_BITS){1'b0}}, value_ff} < cum_next);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff     <= 1'b0;
         min_prob_ff <= 16'd66;
         eta_ff      <= 16'd32768;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RULE:     rule_ff     <= csr_wdata[0];
            CSR_MIN_PROB: min_prob_ff <= csr_wdata;
            CSR_ETA:      eta_ff      <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // live mask and count
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.load_write) begin
         live_ff  <= live_in;
         count_ff <= popcount(live_in);
      end else if (cmd.apply_surv) begin
         live_ff  <= surv_ff;
         count_ff <= popcount(surv_ff);
      end
   end

   // weight arrays
   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         weights_ff[idx_ff] <= value_ff;
         pend_ff[idx_ff]    <= value_ff;
      end
      if (cmd.mul_write) pend_ff[idx_ff] <= w_prod[31:16];
      if (cmd.norm_write) begin
         weights_ff[idx_ff] <= norm_val;
         pend_ff[idx_ff]    <= norm_val;
      end
      if (cmd.sync_write && live_ff[idx_ff]) pend_ff[idx_ff] <= w_cur;
   end

   // item fields, index, sum, divider, walk
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= req_mode;
         last_ff  <= req_last;
         value_ff <= req_value;
         idx_ff   <= req_slot;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.mul_factor) factor_ff <= factor_in;
      if (cmd.sum_clr) total_ff <= '0;
      else if (cmd.sum_acc && live_ff[idx_ff]) total_ff <= total_ff + src_ext;
      if (cmd.div_start) begin
         rem_ff  <= src_ext;
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
         quo_ff  <= {quo_ff[FRAC_BITS-1:0], ge};
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.surv_clr) surv_ff <= '0;
      else if (cmd.norm_write && cmd.gather) surv_ff[idx_ff] <= norm_val >= min_prob_ff;
      if (cmd.walk_clr) begin
         cum_ff  <= '0;
         pick_ff <= '0;
      end else if (cmd.walk_step && live_ff[idx_ff]) begin
         cum_ff  <= cum_next;
         pick_ff <= idx_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_ff;
         if (cmd.rsp_status == ST_SELECTED) rsp_chosen_ff <= pick_ff;
         else rsp_chosen_ff <= (count_ff == CNT_W'(1)) ? sole : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_model = rsp_chosen_ff;
   assign rsp_live_count   = rsp_count_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/mwus_ctrl.sv -----
// sequencing state machine for loads, update passes and selections
`default_nettype none
module mwus_ctrl import mwus_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [13:0] {
      S_IDLE     = 14'h0001,
      S_DISPATCH = 14'h0002,
      S_MUL1     = 14'h0004,
      S_MUL2     = 14'h0008,
      S_FIN      = 14'h0010,
      S_SUM      = 14'h0020,
      S_CHECK    = 14'h0040,
      S_NORM_SEL = 14'h0080,
      S_DIV      = 14'h0100,
      S_NORM_WR  = 14'h0200,
      S_POST     = 14'h0400,
      S_SYNC     = 14'h0800,
      S_WALK     = 14'h1000,
      S_RESP     = 14'h2000
   } state_type;

   state_type  state_ff, state_in;
   logic       kind_upd_ff, kind_upd_in;
   logic       second_ff, second_in;
   logic       src_pend_ff, src_pend_in;
   status_type code_ff, code_in;
   logic       first_upd;

   assign first_upd = kind_upd_ff && !second_ff;

   always_comb begin
      state_in    = state_ff;
      kind_upd_in = kind_upd_ff;
      second_in   = second_ff;
      src_pend_in = src_pend_ff;
      code_in     = code_ff;
      cmd         = '0;
      cmd.src_pend   = src_pend_ff;
      cmd.rsp_status = code_ff;
      cmd.gather     = first_upd;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            second_in = 1'b0;
            case (stat.mode)
               MODE_LOAD: begin
                  cmd.load_write = 1'b1;
                  kind_upd_in    = 1'b0;
                  src_pend_in    = 1'b0;
                  code_in        = ST_LOADED;
                  if (stat.last) begin
                     cmd.idx_clr = 1'b1;
                     cmd.sum_clr = 1'b1;
                     state_in    = S_SUM;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               MODE_LIKE: begin
                  kind_upd_in = 1'b1;
                  code_in     = ST_UPDATED;
                  if (stat.cur_live) state_in = S_MUL1;
                  else if (stat.last) state_in = S_FIN;
                  else state_in = S_IDLE;
               end
               MODE_SELECT: begin
                  cmd.idx_clr  = 1'b1;
                  cmd.walk_clr = 1'b1;
                  code_in      = ST_SELECTED;
                  state_in     = S_WALK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_MUL1: begin
            cmd.mul_factor = 1'b1;
            state_in       = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_write = 1'b1;
            state_in      = stat.last ? S_FIN : S_IDLE;
         end
         // pass end: skip on at most one live model, else sum the new weights
         S_FIN: begin
            cmd.idx_clr = 1'b1;
            if (stat.count_le1) begin
               code_in  = ST_SKIPPED;
               state_in = S_SYNC;
            end else begin
               cmd.sum_clr = 1'b1;
               src_pend_in = 1'b1;
               state_in    = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_acc = 1'b1;
            if (stat.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_CHECK;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_CHECK: begin
            if (first_upd) begin
               if (stat.reject) begin
                  code_in  = ST_REJECTED;
                  state_in = S_SYNC;
               end else begin
                  cmd.surv_clr = 1'b1;
                  state_in     = S_NORM_SEL;
               end
            end else if (stat.total_zero) begin
               state_in = S_RESP;
            end else begin
               state_in = S_NORM_SEL;
            end
         end
         // normalize each live weight through the divider
         S_NORM_SEL: begin
            if (stat.cur_live) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (stat.idx_last) begin
               state_in = S_POST;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_NORM_WR;
         end
         S_NORM_WR: begin
            cmd.norm_write = 1'b1;
            if (stat.idx_last) begin
               state_in = S_POST;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_NORM_SEL;
            end
         end
         // on a first update pass, prune and renormalize the survivors, else respond
         S_POST: begin
            if (first_upd && stat.prune) begin
               cmd.apply_surv = 1'b1;
               cmd.idx_clr    = 1'b1;
               cmd.sum_clr    = 1'b1;
               second_in      = 1'b1;
               src_pend_in    = 1'b0;
               state_in       = S_SUM;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SYNC: begin
            cmd.sync_write = 1'b1;
            if (stat.idx_last) state_in = S_RESP;
            else cmd.idx_inc = 1'b1;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_hit || stat.idx_last) state_in = S_RESP;
            else cmd.idx_inc = 1'b1;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         kind_upd_ff <= 1'b0;
         second_ff   <= 1'b0;
         src_pend_ff <= 1'b0;
         code_ff     <= ST_LOADED;
      end else begin
         state_ff    <= state_in;
         kind_upd_ff <= kind_upd_in;
         second_ff   <= second_in;
         src_pend_ff <= src_pend_in;
         code_ff     <= code_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/model_weight_update_select.sv -----
// top level of the model weight update and selection block
`default_nettype none
// Keeps a Q0.16 weight for each of 16 models and a live mask. One transaction
// is handled at a time. A select walks the live weights lowest slot first.
// The end of a load or update pass sums the weights, then visits every slot,
// and each live weight is normalized in a bit-serial divider. When pruning
// removes models, the sum and the normalization run again for the survivors.
// A rejected or skipped pass ends in a copy sweep instead. The next
// transaction is taken while the previous result waits in the output register.
module model_weight_update_select import mwus_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_mode,
   input  wire logic [IDX_W-1:0]     req_slot,
   input  wire logic [FRAC_BITS-1:0] req_value,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [IDX_W-1:0]          rsp_chosen_model,
   output logic [CNT_W-1:0]          rsp_live_count
);
`include "model_weight_update_select_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   mwus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mwus_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_chosen_model (rsp_chosen_model),
      .rsp_live_count   (rsp_live_count)
   );

   // checks
   `MWUS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `MWUS_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, rsp_live_count <= CNT_W'(NUM_MODELS), "live count out of range")
   `MWUS_ASSERT_IMPLY(a_chosen_zero, clock, reset, rsp_valid && rsp_live_count != CNT_W'(1) && rsp_status != ST_SELECTED, rsp_chosen_model == '0, "chosen model without sole survivor")
endmodule
`default_nettype wire
